// ----- hdl/sha256_message_hash_macros.svh -----
// Assertion macros shared by the checker.
`ifndef SHA256_MESSAGE_HASH_MACROS_SVH
`define SHA256_MESSAGE_HASH_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hdl/sha_pkg.sv -----
// Types and constants for the SHA-256 message hash.
`default_nettype none
package sha_pkg;
	typedef struct packed {
		logic [7:0] message_byte;
		logic       is_last;
	} sha_in_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic        last_word;
	} sha_out_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// control handed from the sequencer to the compression core
	typedef struct packed {
		logic       start;
		logic [5:0] round;
		logic       step;
		logic       finish;
	} sha_core_ctl_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int amt);
		rotr = (v >> amt) | (v << (32 - amt));
	endfunction
endpackage
`default_nettype wire

// ----- hdl/sha_sched.sv -----
// Message schedule: 16-word window memory with one word produced per round.
`default_nettype none
module sha_sched
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        wr_en,
	input  wire logic [3:0]  wr_addr,
	input  wire logic [31:0] wr_data,
	input  wire logic        step,
	input  wire logic [5:0]  round,
	output logic [31:0]      w
);
	// window held in registers: taps read at fixed places
	logic [31:0] win_q [16];
	logic [31:0] nxt, x, y;

	always_comb begin
		x = win_q[1];
		y = win_q[14];
		nxt = win_q[0] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + win_q[9]
			+ (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
		w = win_q[0];
	end

	// load bytes-as-words, then shift one word each round
	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_q[wr_addr] <= wr_data;
		end else if (step) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= (round < 6'd48) ? nxt : nxt;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/sha_core.sv -----
// Compression rounds and the chaining-hash memory.
`default_nettype none
module sha_core
	import sha_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sha_core_ctl_t ctl,
	input  wire logic [31:0]   w,
	input  wire logic          init,
	input  wire logic [1:0]    rd_word,
	output logic [63:0]        rd_data
);
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] t1, t2, e, a;

	always_comb begin
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[ctl.round] + w;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		rd_data = {h_q[{rd_word, 1'b0}], h_q[{rd_word, 1'b1}]};
	end

	// chaining words: reset and re-init to the initial values, add the working variables at finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
		end else if (init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
		end else if (ctl.finish) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	// working variables: loaded from the chaining words on start, then one round per step
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/sha256_message_hash.sv -----
// SHA-256 message hash top level: byte buffer memory, sequencer, output.
// A byte that fills a block stalls the input while the block is loaded and
// compressed and the chaining words are updated; other bytes go back to back.
// Last byte: pad byte, zero fill and length, one or two compressions, then four
// digest words, one per cycle when the output is not stalled.
// Input waits on each compression, since there is a single round unit.
// Reset clears sequencer, counts and chaining words to initial values.
`default_nettype none
module sha256_message_hash
	import sha_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire sha_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output sha_out_t      out_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        final_q;   // last byte taken, padding and digest follow
	logic        padded_q;  // pad byte already written for this message
	logic        extra_q;   // pad fell past byte 55, length goes in a further block
	logic [5:0]  cnt_q;
	logic [1:0]  ow_q;

	// block buffer memory: one byte write, one registered read of a 32-bit word
	logic [31:0] buf_mem [16];
	logic        mem_we;
	logic [5:0]  mem_wa;
	logic [7:0]  mem_wd;
	logic [31:0] rd_s1;
	logic [3:0]  rd_addr;
	logic        ld_s1;
	logic [3:0]  ld_addr_s1;

	sha_core_ctl_t ctl;
	logic [31:0]   w;
	logic          init;
	logic [63:0]   hw;
	logic          in_acc;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (mem_we) buf_mem[mem_wa[5:2]][{~mem_wa[1:0], 3'd0} +: 8] <= mem_wd;
		rd_s1 <= buf_mem[rd_addr];
	end

	// write source: message byte, pad byte, zero or length byte
	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q;
		mem_wd = in_data.message_byte;
		if (state_q == ST_IDLE) begin
			mem_we = in_acc;
		end else if (state_q == ST_PAD) begin
			mem_we = 1'b1;
			if (!padded_q) begin
				mem_wd = PAD_BYTE;
			end else if (fill_q >= 6'd56 && !extra_q) begin
				mem_wd = bits_q[6'd63 - {fill_q[2:0], 3'd0} -: 8];
			end else begin
				mem_wd = 8'h00;
			end
		end
		rd_addr = cnt_q[3:0];
	end

	always_comb begin
		ctl.start  = (state_q == ST_LOAD) && (cnt_q == 6'd16);
		ctl.step   = (state_q == ST_RND);
		ctl.round  = cnt_q;
		ctl.finish = (state_q == ST_FIN);
		init = (state_q == ST_OUT) && !out_stall && (ow_q == 2'd3);
	end

	sha_sched u_sched (
		.clk(clk), .wr_en(ld_s1), .wr_addr(ld_addr_s1), .wr_data(rd_s1),
		.step(ctl.step), .round(cnt_q), .w(w));

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .w(w), .init(init),
		.rd_word(ow_q), .rd_data(hw));

	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word = hw;
	assign out_data.last_word   = (ow_q == 2'd3);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			final_q <= 1'b0;
			padded_q <= 1'b0;
			extra_q <= 1'b0;
			cnt_q <= '0;
			ow_q <= '0;
			ld_s1 <= 1'b0;
			ld_addr_s1 <= '0;
		end else begin
			ld_s1 <= (state_q == ST_LOAD) && (cnt_q < 6'd16);
			ld_addr_s1 <= cnt_q[3:0];
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						bits_q <= bits_q + 64'd8;
						fill_q <= fill_q + 6'd1;
						cnt_q <= '0;
						if (in_data.is_last) final_q <= 1'b1;
						if (fill_q == 6'd63) begin
							state_q <= ST_LOAD;
						end else if (in_data.is_last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// pad byte first, then zero fill and length
					cnt_q <= '0;
					fill_q <= fill_q + 6'd1;
					if (!padded_q) begin
						padded_q <= 1'b1;
						if (fill_q >= 6'd56) extra_q <= 1'b1;
					end
					if (fill_q == 6'd63) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (cnt_q == 6'd16) begin
						cnt_q <= '0;
						state_q <= ST_RND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_RND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else if (!padded_q) begin
						// last byte filled the block: pad in a fresh one
						state_q <= ST_PAD;
					end else if (extra_q) begin
						// length block still to come
						extra_q <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						ow_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						ow_q <= ow_q + 2'd1;
						if (ow_q == 2'd3) begin
							state_q <= ST_IDLE;
							fill_q <= '0;
							bits_q <= '0;
							final_q <= 1'b0;
							padded_q <= 1'b0;
							extra_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/sha_checker.sv -----
// Port checker for the SHA-256 message hash, bound to the top level.
`default_nettype none
`include "sha256_message_hash_macros.svh"
module sha_checker
	import sha_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_stall,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire sha_out_t out_data
);
	`SHA_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, in_stall, "input taken during digest")
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled digest changed")
	`SHA_ASSERT_NEXT(a_last_ends, clk, arst_n, out_valid && !out_stall && out_data.last_word, !out_valid, "digest runs past last word")
endmodule
bind sha256_message_hash sha_checker u_sha_checker (.*);
`default_nettype wire
